// ===== sv/jpeg_huffman_block_decoder_assert.svh =====
`ifndef JPEG_HUFFMAN_BLOCK_DECODER_ASSERT_SVH
`define JPEG_HUFFMAN_BLOCK_DECODER_ASSERT_SVH
// same-cycle implication and next-cycle implication, clocked on clk
`ifndef SYNTHESIS
`define JHBD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jhbd assertion failed");
`define JHBD_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jhbd assertion failed");
`else
`define JHBD_ASSERT_IMP(label, ante, cons)
`define JHBD_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/jhbd_pkg.sv =====
package jhbd_pkg;
	localparam int HUFF_TABLES_PER_CLASS_DEF = 2;
	localparam int MAX_SYMBOLS_DEF = 256;
	localparam int QUANT_TABLES_DEF = 4;
	localparam int COMPONENTS_DEF = 4;

	localparam logic [15:0] DC_BIAS = 16'd1024;
	localparam logic [7:0] BYTE_FF = 8'hFF;
	localparam logic [3:0] ZRL_RUN = 4'd15;
	localparam logic [4:0] MAX_CODE_LEN = 5'd16;

	localparam logic KIND_COEF = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		CMD_LOAD_COUNT = 3'd0,
		CMD_LOAD_SYMBOL = 3'd1,
		CMD_LOAD_QUANT = 3'd2,
		CMD_BUILD = 3'd3,
		CMD_START = 3'd4,
		CMD_DATA = 3'd5,
		CMD_CLEAR = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK = 2'd0,
		STAT_BAD_TABLE = 2'd1,
		STAT_BAD_CODE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_DC = 2'd1,
		PH_AC = 2'd2,
		PH_EXTRA = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BLD_RD,
		ST_BLD_CMP,
		ST_BLD_CLR,
		ST_BLD_OUT,
		ST_DEC_RD,
		ST_DEC_CMP,
		ST_DEC_SYM,
		ST_EXTRA,
		ST_Q_WAIT,
		ST_EMIT,
		ST_EOB,
		ST_FAIL
	} state_t;

	function automatic logic [5:0] zz_natural(input logic [5:0] k);
		logic [5:0] p;
		case (k)
			6'd0: p = 6'd0;    6'd1: p = 6'd1;    6'd2: p = 6'd8;    6'd3: p = 6'd16;
			6'd4: p = 6'd9;    6'd5: p = 6'd2;    6'd6: p = 6'd3;    6'd7: p = 6'd10;
			6'd8: p = 6'd17;   6'd9: p = 6'd24;   6'd10: p = 6'd32;  6'd11: p = 6'd25;
			6'd12: p = 6'd18;  6'd13: p = 6'd11;  6'd14: p = 6'd4;   6'd15: p = 6'd5;
			6'd16: p = 6'd12;  6'd17: p = 6'd19;  6'd18: p = 6'd26;  6'd19: p = 6'd33;
			6'd20: p = 6'd40;  6'd21: p = 6'd48;  6'd22: p = 6'd41;  6'd23: p = 6'd34;
			6'd24: p = 6'd27;  6'd25: p = 6'd20;  6'd26: p = 6'd13;  6'd27: p = 6'd6;
			6'd28: p = 6'd7;   6'd29: p = 6'd14;  6'd30: p = 6'd21;  6'd31: p = 6'd28;
			6'd32: p = 6'd35;  6'd33: p = 6'd42;  6'd34: p = 6'd49;  6'd35: p = 6'd56;
			6'd36: p = 6'd57;  6'd37: p = 6'd50;  6'd38: p = 6'd43;  6'd39: p = 6'd36;
			6'd40: p = 6'd29;  6'd41: p = 6'd22;  6'd42: p = 6'd15;  6'd43: p = 6'd23;
			6'd44: p = 6'd30;  6'd45: p = 6'd37;  6'd46: p = 6'd44;  6'd47: p = 6'd51;
			6'd48: p = 6'd58;  6'd49: p = 6'd59;  6'd50: p = 6'd52;  6'd51: p = 6'd45;
			6'd52: p = 6'd38;  6'd53: p = 6'd31;  6'd54: p = 6'd39;  6'd55: p = 6'd46;
			6'd56: p = 6'd53;  6'd57: p = 6'd60;  6'd58: p = 6'd61;  6'd59: p = 6'd54;
			6'd60: p = 6'd47;  6'd61: p = 6'd55;  6'd62: p = 6'd62;  6'd63: p = 6'd63;
			default: p = 6'd63;
		endcase
		return p;
	endfunction
endpackage

// ===== sv/jhbd_req_if.sv =====
interface jhbd_req_if;
	logic valid;
	logic ready;
	logic [2:0] command;
	logic table_class;
	logic table_id;
	logic ac_table_id;
	logic [1:0] quant_id;
	logic [1:0] component;
	logic [7:0] index;
	logic [14:0] value;

	modport source(output valid, command, table_class, table_id, ac_table_id, quant_id,
		component, index, value, input ready);
	modport sink(input valid, command, table_class, table_id, ac_table_id, quant_id,
		component, index, value, output ready);
endinterface

// ===== sv/jhbd_res_if.sv =====
interface jhbd_res_if;
	logic valid;
	logic ready;
	logic kind;
	logic [5:0] position;
	logic signed [15:0] coefficient;
	logic block_end;
	logic [1:0] status;

	modport source(output valid, kind, position, coefficient, block_end, status, input ready);
	modport sink(input valid, kind, position, coefficient, block_end, status, output ready);
endinterface

// ===== sv/jpeg_huffman_block_decoder.sv =====
// Baseline JPEG entropy decoder, one 8x8 block at a time.
// request channel: one command per request (table loads, table build, block start,
// compressed data byte, predictor clear); ready is high only while no command is in work.
// result channel: coefficient results, block end markers, build status and error reports.
// A build walks the 16 code lengths, each with a read of the count memory and a compare,
// and wipes the bound entries of a rejected table. Each Huffman code costs, per bit
// of code length, one read of the code bound memory and one compare; then a symbol
// memory read; then, for a coefficient, the extra bits, the quantizer read, the
// multiply and the result register. The bound memory's single read port sets the pace.
// After reset the count store reads as zero, predictors and bit reader are empty and no
// block is active; symbol and quantizer stores hold nothing valid until loaded.
// A result sits in the output register until taken; while it waits the decoder stalls
// only at its next result, and ready stays low until the command has finished.
`include "jpeg_huffman_block_decoder_assert.svh"

module jpeg_huffman_block_decoder #(
	parameter int HUFF_TABLES_PER_CLASS = jhbd_pkg::HUFF_TABLES_PER_CLASS_DEF,
	parameter int MAX_SYMBOLS = jhbd_pkg::MAX_SYMBOLS_DEF,
	parameter int QUANT_TABLES = jhbd_pkg::QUANT_TABLES_DEF,
	parameter int COMPONENTS = jhbd_pkg::COMPONENTS_DEF
) (
	input logic clk,
	input logic arst_n,
	jhbd_req_if.sink request,
	jhbd_res_if.source result
);
	import jhbd_pkg::*;

	localparam int NHT = 2 * HUFF_TABLES_PER_CLASS;
	localparam int TW = $clog2(NHT);
	localparam int SW = $clog2(MAX_SYMBOLS);
	localparam int QW = (QUANT_TABLES > 1) ? $clog2(QUANT_TABLES) : 1;
	localparam int CW = (COMPONENTS > 1) ? $clog2(COMPONENTS) : 1;
	localparam int CNT_DEPTH = 2 ** (TW + 4);
	localparam int SYM_DEPTH = 2 ** (TW + SW);
	localparam int Q_DEPTH = 2 ** (QW + 6);

	// memories
	logic [7:0] cnt_mem [CNT_DEPTH];
	logic [CNT_DEPTH-1:0] cnt_vld_q;
	logic [36:0] dec_mem [CNT_DEPTH];
	logic [7:0] sym_mem [SYM_DEPTH];
	logic [14:0] q_mem [Q_DEPTH];
	logic [15:0] pred_q [COMPONENTS];

	logic cnt_we, dec_we, sym_we, q_we, pred_we, pred_clr;
	logic [TW+3:0] cnt_wa, cnt_ra, dec_wa, dec_ra;
	logic [7:0] cnt_wd, sym_wd;
	logic [36:0] dec_wd;
	logic [TW+SW-1:0] sym_wa, sym_ra;
	logic [QW+5:0] q_wa, q_ra;
	logic [14:0] q_wd;
	logic [15:0] pred_wd;
	logic [7:0] cnt_rd_s1, sym_rd_s1;
	logic cnt_rdv_s1;
	logic [36:0] dec_rd_s1;
	logic [14:0] q_rd_s1;

	state_t st_q, st_d;
	phase_t phase_q, phase_d;
	logic [31:0] buf_q, buf_d;
	logic [5:0] cnt_q, cnt_d;
	logic ff_q, ff_d, mark_q, mark_d;
	logic [6:0] coef_q, coef_d;
	logic [3:0] pend_q, pend_d;
	logic [4:0] len_q, len_d;
	logic [15:0] code_q, code_d;
	logic [3:0] bi_q, bi_d;
	logic [8:0] bk_q, bk_d;
	logic [17:0] bcode_q, bcode_d;
	logic [TW-1:0] bt_q, bt_d;
	status_t bstat_q, bstat_d;
	logic dc_tid_q, dc_tid_d, ac_tid_q, ac_tid_d;
	logic [QW-1:0] qid_q, qid_d;
	logic [CW-1:0] comp_q, comp_d;
	logic [15:0] op_q, op_d, prod_q, prod_d;
	logic isdc_q, isdc_d;
	logic [5:0] pos_q, pos_d;

	logic out_valid_q, out_load;
	logic out_kind_d, out_end_d;
	logic [5:0] out_pos_d;
	logic [15:0] out_coef_d;
	status_t out_stat_d;
	logic out_kind_q, out_end_q;
	logic [5:0] out_pos_q;
	logic [15:0] out_coef_q;
	logic [1:0] out_stat_q;

	logic can_put, tid_ok;
	logic [TW-1:0] t_cmd, tsel;

	assign can_put = !out_valid_q || result.ready;
	assign tid_ok = int'(request.table_id) < HUFF_TABLES_PER_CLASS;
	assign t_cmd = (request.table_class ? TW'(HUFF_TABLES_PER_CLASS) : TW'(0))
		+ TW'(request.table_id);
	assign tsel = (phase_q == PH_DC) ? TW'(dc_tid_q)
		: TW'(HUFF_TABLES_PER_CLASS) + TW'(ac_tid_q);
	assign request.ready = (st_q == ST_IDLE);

	always_comb begin
		logic [7:0] b;
		logic [7:0] l;
		logic [9:0] ksum;
		logic [17:0] csum;
		logic [17:0] maxc;
		logic signed [18:0] off, sidx;
		logic [5:0] cnt_new;
		logic [15:0] v, diff;
		logic [3:0] r, z;
		logic [5:0] zk;

		st_d = st_q;
		phase_d = phase_q;
		buf_d = buf_q;
		cnt_d = cnt_q;
		ff_d = ff_q;
		mark_d = mark_q;
		coef_d = coef_q;
		pend_d = pend_q;
		len_d = len_q;
		code_d = code_q;
		bi_d = bi_q;
		bk_d = bk_q;
		bcode_d = bcode_q;
		bt_d = bt_q;
		bstat_d = bstat_q;
		dc_tid_d = dc_tid_q;
		ac_tid_d = ac_tid_q;
		qid_d = qid_q;
		comp_d = comp_q;
		op_d = op_q;
		prod_d = prod_q;
		isdc_d = isdc_q;
		pos_d = pos_q;
		cnt_we = 1'b0;
		dec_we = 1'b0;
		sym_we = 1'b0;
		q_we = 1'b0;
		pred_we = 1'b0;
		pred_clr = 1'b0;
		cnt_wa = {t_cmd, 4'(request.index - 8'd1)};
		cnt_wd = request.value[7:0];
		cnt_ra = {bt_q, bi_q};
		dec_wa = {bt_q, bi_q};
		dec_wd = '0;
		dec_ra = {tsel, 4'(len_q - 5'd1)};
		sym_wa = {t_cmd, request.index[SW-1:0]};
		sym_wd = request.value[7:0];
		sym_ra = '0;
		q_wa = {request.quant_id[QW-1:0], request.index[5:0]};
		q_wd = request.value;
		q_ra = '0;
		pred_wd = '0;
		out_load = 1'b0;
		out_kind_d = KIND_COEF;
		out_pos_d = '0;
		out_coef_d = '0;
		out_end_d = 1'b0;
		out_stat_d = STAT_OK;
		b = request.value[7:0];
		l = cnt_rdv_s1 ? cnt_rd_s1 : 8'd0;
		ksum = {1'b0, bk_q} + {2'b0, l};
		csum = bcode_q + {10'b0, l};
		maxc = dec_rd_s1[36:19];
		off = $signed(dec_rd_s1[18:0]);
		sidx = $signed({3'b0, code_q}) + off;
		cnt_new = cnt_q - 6'(len_q);
		v = '0;
		diff = '0;
		r = sym_rd_s1[7:4];
		z = sym_rd_s1[3:0];
		zk = (coef_q > 7'd63) ? 6'd63 : coef_q[5:0];

		case (st_q)
			ST_IDLE: begin
				if (request.valid) begin
					case (cmd_t'(request.command))
						CMD_LOAD_COUNT: begin
							cnt_we = tid_ok && request.index >= 8'd1 && request.index <= 8'd16;
						end
						CMD_LOAD_SYMBOL: begin
							sym_we = tid_ok && int'(request.index) < MAX_SYMBOLS;
						end
						CMD_LOAD_QUANT: begin
							q_we = int'(request.quant_id) < QUANT_TABLES && request.index < 8'd64;
						end
						CMD_BUILD: begin
							if (tid_ok) begin
								bt_d = t_cmd;
								bi_d = '0;
								bk_d = '0;
								bcode_d = '0;
								st_d = ST_BLD_RD;
							end else begin
								bstat_d = STAT_BAD_TABLE;
								st_d = ST_BLD_OUT;
							end
						end
						CMD_START: begin
							if (tid_ok && int'(request.ac_table_id) < HUFF_TABLES_PER_CLASS
								&& int'(request.quant_id) < QUANT_TABLES
								&& int'(request.component) < COMPONENTS) begin
								dc_tid_d = request.table_id;
								ac_tid_d = request.ac_table_id;
								qid_d = request.quant_id[QW-1:0];
								comp_d = request.component[CW-1:0];
								coef_d = '0;
								pend_d = '0;
								phase_d = PH_DC;
								len_d = 5'd1;
								code_d = '0;
								st_d = ST_DEC_RD;
							end
						end
						CMD_DATA: begin
							if (!mark_q) begin
								if (ff_q) begin
									ff_d = 1'b0;
									if (b == 8'd0) begin
										if (cnt_q <= 6'd24) begin
											buf_d = {buf_q[23:0], BYTE_FF};
											cnt_d = cnt_q + 6'd8;
										end
									end else begin
										mark_d = 1'b1;
									end
								end else if (b == BYTE_FF) begin
									ff_d = 1'b1;
								end else if (cnt_q <= 6'd24) begin
									buf_d = {buf_q[23:0], b};
									cnt_d = cnt_q + 6'd8;
								end
								if (phase_q == PH_DC || phase_q == PH_AC) begin
									len_d = 5'd1;
									code_d = '0;
									st_d = ST_DEC_RD;
								end else if (phase_q == PH_EXTRA) begin
									st_d = ST_EXTRA;
								end
							end
						end
						CMD_CLEAR: begin
							pred_clr = 1'b1;
							buf_d = '0;
							cnt_d = '0;
							ff_d = 1'b0;
							mark_d = 1'b0;
						end
						default: ;
					endcase
				end
			end
			ST_BLD_RD: begin
				st_d = ST_BLD_CMP;
			end
			ST_BLD_CMP: begin
				if (int'(ksum) > MAX_SYMBOLS || ksum > 10'd255) begin
					bi_d = '0;
					st_d = ST_BLD_CLR;
				end else begin
					dec_we = 1'b1;
					dec_wd = {csum, 19'($signed({10'b0, bk_q}) - $signed({1'b0, bcode_q}))};
					bk_d = ksum[8:0];
					if (l != 8'd0 && csum >= (18'd1 << ({1'b0, bi_q} + 5'd1))) begin
						bi_d = '0;
						st_d = ST_BLD_CLR;
					end else begin
						bcode_d = {csum[16:0], 1'b0};
						if (bi_q == 4'd15) begin
							bstat_d = STAT_OK;
							st_d = ST_BLD_OUT;
						end else begin
							bi_d = bi_q + 4'd1;
							st_d = ST_BLD_RD;
						end
					end
				end
			end
			ST_BLD_CLR: begin
				dec_we = 1'b1;
				if (bi_q == 4'd15) begin
					bstat_d = STAT_BAD_TABLE;
					st_d = ST_BLD_OUT;
				end else begin
					bi_d = bi_q + 4'd1;
				end
			end
			ST_BLD_OUT: begin
				if (can_put) begin
					out_load = 1'b1;
					out_kind_d = KIND_STATUS;
					out_stat_d = bstat_q;
					st_d = ST_IDLE;
				end
			end
			ST_DEC_RD: begin
				if (len_q > MAX_CODE_LEN || 6'(len_q) > cnt_q) begin
					if (cnt_q >= 6'd16) begin
						st_d = ST_FAIL;
					end else if (mark_q) begin
						buf_d = {buf_q[23:0], 8'd0};
						cnt_d = cnt_q + 6'd8;
						len_d = 5'd1;
						code_d = '0;
					end else begin
						st_d = ST_IDLE;
					end
				end else begin
					code_d = {code_q[14:0], buf_q[5'(cnt_new)]};
					st_d = ST_DEC_CMP;
				end
			end
			ST_DEC_CMP: begin
				if ({2'b0, code_q} < maxc) begin
					cnt_d = cnt_new;
					buf_d = buf_q & ~(32'hFFFF_FFFF << cnt_new);
					if (sidx < 0 || sidx >= 19'(MAX_SYMBOLS)) begin
						st_d = ST_FAIL;
					end else begin
						sym_ra = {tsel, sidx[SW-1:0]};
						st_d = ST_DEC_SYM;
					end
				end else begin
					len_d = len_q + 5'd1;
					st_d = ST_DEC_RD;
				end
			end
			ST_DEC_SYM: begin
				if (phase_q == PH_DC) begin
					if (sym_rd_s1 > 8'd15) begin
						st_d = ST_FAIL;
					end else begin
						pend_d = z;
						phase_d = PH_EXTRA;
						st_d = ST_EXTRA;
					end
				end else if (z != 4'd0) begin
					coef_d = coef_q + 7'(r);
					pend_d = z;
					phase_d = PH_EXTRA;
					st_d = ST_EXTRA;
				end else if (r == ZRL_RUN && coef_q + 7'd16 < 7'd64) begin
					coef_d = coef_q + 7'd16;
					len_d = 5'd1;
					code_d = '0;
					st_d = ST_DEC_RD;
				end else begin
					st_d = ST_EOB;
				end
			end
			ST_EXTRA: begin
				if (cnt_q < 6'(pend_q)) begin
					if (mark_q) begin
						buf_d = {buf_q[23:0], 8'd0};
						cnt_d = cnt_q + 6'd8;
					end else begin
						st_d = ST_IDLE;
					end
				end else begin
					cnt_new = cnt_q - 6'(pend_q);
					v = 16'((buf_q >> cnt_new) & ~(32'hFFFF_FFFF << pend_q));
					if (pend_q == 4'd0) begin
						diff = '0;
					end else if (v < (16'd1 << (pend_q - 4'd1))) begin
						diff = v - (16'd1 << pend_q) + 16'd1;
					end else begin
						diff = v;
					end
					cnt_d = cnt_new;
					buf_d = buf_q & ~(32'hFFFF_FFFF << cnt_new);
					if (coef_q == 7'd0) begin
						pred_we = 1'b1;
						pred_wd = pred_q[comp_q] + diff;
						op_d = pred_wd;
						q_ra = {qid_q, 6'd0};
						isdc_d = 1'b1;
						pos_d = '0;
					end else begin
						pos_d = zz_natural(zk);
						q_ra = {qid_q, zz_natural(zk)};
						coef_d = coef_q + 7'd1;
						op_d = diff;
						isdc_d = 1'b0;
					end
					st_d = ST_Q_WAIT;
				end
			end
			ST_Q_WAIT: begin
				prod_d = {1'b0, q_rd_s1} * op_q;
				st_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (can_put) begin
					out_load = 1'b1;
					out_pos_d = pos_q;
					out_coef_d = isdc_q ? prod_q + DC_BIAS : prod_q;
					out_end_d = !isdc_q && coef_q >= 7'd64;
					len_d = 5'd1;
					code_d = '0;
					if (isdc_q) begin
						coef_d = 7'd1;
						phase_d = PH_AC;
						st_d = ST_DEC_RD;
					end else if (coef_q >= 7'd64) begin
						phase_d = PH_IDLE;
						st_d = ST_IDLE;
					end else begin
						phase_d = PH_AC;
						st_d = ST_DEC_RD;
					end
				end
			end
			ST_EOB: begin
				if (can_put) begin
					out_load = 1'b1;
					out_end_d = 1'b1;
					phase_d = PH_IDLE;
					st_d = ST_IDLE;
				end
			end
			ST_FAIL: begin
				if (can_put) begin
					out_load = 1'b1;
					out_end_d = 1'b1;
					out_stat_d = STAT_BAD_CODE;
					buf_d = '0;
					cnt_d = '0;
					phase_d = PH_IDLE;
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			buf_q <= '0;
			cnt_q <= '0;
			ff_q <= 1'b0;
			mark_q <= 1'b0;
			coef_q <= '0;
			pend_q <= '0;
			len_q <= 5'd1;
			code_q <= '0;
			bi_q <= '0;
			bk_q <= '0;
			bcode_q <= '0;
			bt_q <= '0;
			bstat_q <= STAT_OK;
			dc_tid_q <= 1'b0;
			ac_tid_q <= 1'b0;
			qid_q <= '0;
			comp_q <= '0;
			isdc_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_vld_q <= '0;
		end else begin
			st_q <= st_d;
			phase_q <= phase_d;
			buf_q <= buf_d;
			cnt_q <= cnt_d;
			ff_q <= ff_d;
			mark_q <= mark_d;
			coef_q <= coef_d;
			pend_q <= pend_d;
			len_q <= len_d;
			code_q <= code_d;
			bi_q <= bi_d;
			bk_q <= bk_d;
			bcode_q <= bcode_d;
			bt_q <= bt_d;
			bstat_q <= bstat_d;
			dc_tid_q <= dc_tid_d;
			ac_tid_q <= ac_tid_d;
			qid_q <= qid_d;
			comp_q <= comp_d;
			isdc_q <= isdc_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cnt_we) begin
				cnt_vld_q[cnt_wa] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < COMPONENTS; i++) begin
				pred_q[i] <= '0;
			end
		end else if (pred_clr) begin
			for (int i = 0; i < COMPONENTS; i++) begin
				pred_q[i] <= '0;
			end
		end else if (pred_we) begin
			pred_q[comp_q] <= pred_wd;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		prod_q <= prod_d;
		pos_q <= pos_d;
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_pos_q <= out_pos_d;
			out_coef_q <= out_coef_d;
			out_end_q <= out_end_d;
			out_stat_q <= out_stat_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		cnt_rd_s1 <= cnt_mem[cnt_ra];
		cnt_rdv_s1 <= cnt_vld_q[cnt_ra];
	end

	always_ff @(posedge clk) begin
		if (dec_we) begin
			dec_mem[dec_wa] <= dec_wd;
		end
		dec_rd_s1 <= dec_mem[dec_ra];
	end

	always_ff @(posedge clk) begin
		if (sym_we) begin
			sym_mem[sym_wa] <= sym_wd;
		end
		sym_rd_s1 <= sym_mem[sym_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			q_mem[q_wa] <= q_wd;
		end
		q_rd_s1 <= q_mem[q_ra];
	end

	assign result.valid = out_valid_q;
	assign result.kind = out_kind_q;
	assign result.position = out_pos_q;
	assign result.coefficient = out_coef_q;
	assign result.block_end = out_end_q;
	assign result.status = out_stat_q;

	`JHBD_ASSERT_IMP(a_cnt_max, 1'b1, cnt_q <= 6'd32)
	`JHBD_ASSERT_NXT(a_fail_empties, st_q == ST_FAIL && can_put, cnt_q == 6'd0 && phase_q == PH_IDLE)
	`JHBD_ASSERT_IMP(a_status_no_end, out_valid_q && out_kind_q == KIND_STATUS, !out_end_q)
	`JHBD_ASSERT_IMP(a_idle_no_decode, phase_q == PH_IDLE, !(st_q == ST_DEC_RD || st_q == ST_DEC_CMP || st_q == ST_DEC_SYM || st_q == ST_EXTRA || st_q == ST_Q_WAIT))
endmodule
